>>> hw/rtl/fps_pkg.sv
// Shared widths, payload types and divider stage type for the four-anchor position solver.
package fps_pkg;

  localparam int CW       = 16;  // coordinate, range and result width
  localparam int NUM_ANCH = 4;
  localparam int DIMS     = 3;
  localparam int REG_W    = 48;  // one anchor register: x, y, z
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;
  localparam int IDX_LSB  = 3;   // registers sit on 8-byte boundaries
  localparam int IDX_W    = ADDR_W - IDX_LSB;

  localparam int AW   = CW + 1;    // anchor difference
  localparam int SQW  = 2 * CW;    // square of a coordinate or range
  localparam int BW   = SQW + 2;   // right-hand side of one sphere row
  localparam int DBW  = BW + 1;    // right-hand side difference
  localparam int PW   = 2 * AW;    // product inside a 2x2 minor
  localparam int CFW  = PW + 1;    // 2x2 cofactor
  localparam int EPW  = AW + CFW;  // denominator term
  localparam int NPW  = DBW + CFW; // numerator term
  localparam int EW   = EPW + 2;   // 3x3 determinant of the differences
  localparam int NW   = NPW + 2;   // 3x3 numerator determinant
  localparam int NMW  = NW;        // numerator magnitude
  localparam int DENW = EW + 1;    // twice the determinant magnitude
  localparam int QW   = CW;        // quotient bits kept before saturation

  typedef struct packed {
    logic signed [CW-1:0] range_zero;
    logic signed [CW-1:0] range_one;
    logic signed [CW-1:0] range_two;
    logic signed [CW-1:0] range_three;
  } solve_in_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic                 degenerate;
    logic                 clipped;
  } solve_out_t;

  typedef struct packed {
    logic [EW-1:0]            e;
    logic [DIMS-1:0][NW-1:0]  n;
  } div_in_t;

  typedef struct packed {
    logic [DIMS-1:0][NMW-1:0] rem;
    logic [DIMS-1:0][QW-1:0]  quo;
    logic [DIMS-1:0]          ovf;
    logic [DIMS-1:0]          neg;
    logic [DENW-1:0]          den;
    logic                     degen;
  } div_stage_t;

endpackage

>>> hw/rtl/fps_divider.sv
// Pipelined restoring divider giving -n/(2e) per coordinate, truncated and saturated.
module fps_divider #(
  parameter int SAT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  fps_pkg::div_in_t   din,
  output logic               out_valid,
  output fps_pkg::solve_out_t dout
);
  import fps_pkg::*;

  localparam int QW1 = QW + 1;
  localparam logic [QW1-1:0] HALF    = QW1'(1) << (SAT_BITS - 1);
  localparam logic [QW1-1:0] HALF_M1 = HALF - QW1'(1);
  localparam logic [QW-1:0]  LOW     = QW'(QW1'(0) - HALF);
  localparam logic [QW-1:0]  HIGH    = QW'(HALF_M1);

  div_stage_t       st [0:QW+1];
  logic [QW+1:0]    sv;
  div_stage_t       pre;
  div_stage_t       chk;
  logic [EW-1:0]    emag;
  solve_out_t       fmt;
  logic [QW-1:0]    val [DIMS];
  logic             big;
  logic             clip;

  // Magnitudes, signs and the doubled denominator.
  always_comb begin
    pre = '0;
    emag = din.e[EW-1] ? EW'(-$signed(din.e)) : din.e;
    pre.den = DENW'(emag) << 1;
    pre.degen = (din.e == '0);
    for (int c = 0; c < DIMS; c++) begin
      pre.neg[c] = (din.n[c][NW-1] == din.e[EW-1]);
      pre.rem[c] = din.n[c][NW-1] ? NMW'(-$signed(din.n[c])) : din.n[c];
    end
  end

  // A quotient of 2^QW or more always saturates.
  always_comb begin
    chk = st[0];
    for (int c = 0; c < DIMS; c++) begin
      chk.ovf[c] = (st[0].rem[c] >= (NMW'(st[0].den) << QW));
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= pre;
    st[1] <= chk;
    if (rst) begin
      sv[1:0] <= '0;
    end else begin
      sv[0] <= in_valid;
      sv[1] <= sv[0];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_bit
    localparam int BIT = QW - 1 - g;
    div_stage_t nxt;
    logic [NMW-1:0] cand;

    always_comb begin
      nxt  = st[g+1];
      cand = NMW'(st[g+1].den) << BIT;
      for (int c = 0; c < DIMS; c++) begin
        if (st[g+1].rem[c] >= cand) begin
          nxt.rem[c]      = st[g+1].rem[c] - cand;
          nxt.quo[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      st[g+2] <= nxt;
      if (rst) begin
        sv[g+2] <= 1'b0;
      end else begin
        sv[g+2] <= sv[g+1];
      end
    end
  end

  always_comb begin
    clip = 1'b0;
    big  = 1'b0;
    for (int c = 0; c < DIMS; c++) begin
      if (st[QW+1].neg[c]) begin
        big    = st[QW+1].ovf[c] || ({1'b0, st[QW+1].quo[c]} > HALF);
        val[c] = big ? LOW : QW'(0) - st[QW+1].quo[c];
      end else begin
        big    = st[QW+1].ovf[c] || ({1'b0, st[QW+1].quo[c]} > HALF_M1);
        val[c] = big ? HIGH : st[QW+1].quo[c];
      end
      clip = clip | big;
    end
    fmt = '0;
    if (st[QW+1].degen) begin
      fmt.degenerate = 1'b1;
    end else begin
      fmt.pos_x   = val[0];
      fmt.pos_y   = val[1];
      fmt.pos_z   = val[2];
      fmt.clipped = clip;
    end
  end

  always_ff @(posedge clk) begin
    dout <= fmt;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[QW+1];
    end
  end

endmodule

>>> hw/rtl/four_anchor_position_solver.sv
// Top level of the four-anchor position solver: anchor registers, determinant pipeline, divider.
// The result of a start transfer passes five determinant stages and a nineteen-stage divider
// whose last stage is the output register, and comes out with done high.
// Throughput: one range set per clock cycle while busy is low; busy is high only in the cycle
// after reset.
// The receiver cannot stall, so every stage advances on every clock.
// Reset (rst, synchronous) clears all valid bits and the four anchor registers to zero.
module four_anchor_position_solver #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  fps_pkg::solve_in_t          item,
  output logic                        done,
  output fps_pkg::solve_out_t         result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fps_pkg::ADDR_W-1:0]  paddr,
  input  logic [fps_pkg::DATA_W-1:0]  pwdata,
  output logic [fps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import fps_pkg::*;

  // Saturation width: the result field is 16 bits, so wider settings act as 16.
  localparam int SAT_BITS = (COORD_BITS > CW) ? CW : ((COORD_BITS < 2) ? 2 : COORD_BITS);
  // Edges from a start transfer to the edge that takes its result.
  localparam int LAT = 5 + 2 + QW + 1;

  // Anchor registers, written through the APB port.
  logic [REG_W-1:0] anchor [NUM_ANCH];
  logic [IDX_W-1:0] reg_idx;
  logic             acc;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:IDX_LSB];
  assign prdata  = DATA_W'(anchor[reg_idx]);
  assign acc     = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ANCH; i++) begin
        anchor[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      anchor[reg_idx] <= pwdata[REG_W-1:0];
    end
  end

  // busy is only raised for the cycle after reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 1: squares of the ranges and coordinates, and the anchor differences
  // taken relative to anchor 0. The anchors are sampled with the item here, so
  // nothing later in the pipe looks at the registers again.
  logic signed [CW-1:0]  coord [NUM_ANCH][DIMS];
  logic signed [CW-1:0]  rng   [NUM_ANCH];
  logic                  v1;
  logic signed [SQW-1:0] dsq1 [NUM_ANCH];
  logic signed [SQW-1:0] csq1 [NUM_ANCH][DIMS];
  logic signed [AW-1:0]  a1   [DIMS][DIMS];

  always_comb begin
    rng[0] = item.range_zero;
    rng[1] = item.range_one;
    rng[2] = item.range_two;
    rng[3] = item.range_three;
    for (int i = 0; i < NUM_ANCH; i++) begin
      for (int j = 0; j < DIMS; j++) begin
        coord[i][j] = $signed(anchor[i][CW*j +: CW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ANCH; i++) begin
      dsq1[i] <= SQW'(rng[i]) * SQW'(rng[i]);
      for (int j = 0; j < DIMS; j++) begin
        csq1[i][j] <= SQW'(coord[i][j]) * SQW'(coord[i][j]);
      end
    end
    for (int i = 0; i < DIMS; i++) begin
      for (int j = 0; j < DIMS; j++) begin
        a1[i][j] <= AW'(coord[i+1][j]) - AW'(coord[0][j]);
      end
    end
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  // Stage 2: right-hand side of each sphere row, and the two products of every
  // 2x2 minor of the difference matrix.
  logic                 v2;
  logic signed [BW-1:0] b2  [NUM_ANCH];
  logic signed [PW-1:0] p2a [DIMS][DIMS];
  logic signed [PW-1:0] p2b [DIMS][DIMS];
  logic signed [AW-1:0] a2  [DIMS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ANCH; i++) begin
      b2[i] <= BW'(dsq1[i]) - BW'(csq1[i][0]) - BW'(csq1[i][1]) - BW'(csq1[i][2]);
    end
    for (int i = 0; i < DIMS; i++) begin
      // Rows r, s and columns p, q are those left when row i and column k go.
      for (int k = 0; k < DIMS; k++) begin
        p2a[i][k] <= PW'(a1[(i == 0) ? 1 : 0][(k == 0) ? 1 : 0])
                   * PW'(a1[(i == 2) ? 1 : 2][(k == 2) ? 1 : 2]);
        p2b[i][k] <= PW'(a1[(i == 0) ? 1 : 0][(k == 2) ? 1 : 2])
                   * PW'(a1[(i == 2) ? 1 : 2][(k == 0) ? 1 : 0]);
      end
      a2[i] <= a1[i][0];
    end
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // Stage 3: signed cofactors and right-hand side differences.
  logic                  v3;
  logic signed [CFW-1:0] cof3 [DIMS][DIMS];
  logic signed [DBW-1:0] db3  [DIMS];
  logic signed [AW-1:0]  a3   [DIMS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIMS; i++) begin
      for (int k = 0; k < DIMS; k++) begin
        if (((i + k) % 2) == 1) begin
          cof3[i][k] <= CFW'(p2b[i][k]) - CFW'(p2a[i][k]);
        end else begin
          cof3[i][k] <= CFW'(p2a[i][k]) - CFW'(p2b[i][k]);
        end
      end
      db3[i] <= DBW'(b2[i+1]) - DBW'(b2[0]);
      a3[i]  <= a2[i];
    end
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // Stage 4: the terms of the determinant (along the x column) and of the three
  // numerators, each with the right-hand side in place of one column.
  logic                  v4;
  logic signed [EPW-1:0] ep4 [DIMS];
  logic signed [NPW-1:0] np4 [DIMS][DIMS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIMS; i++) begin
      ep4[i] <= EPW'(a3[i]) * EPW'(cof3[i][0]);
      for (int k = 0; k < DIMS; k++) begin
        np4[k][i] <= NPW'(db3[i]) * NPW'(cof3[i][k]);
      end
    end
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  // Stage 5: sums. Each coordinate is then -n/(2e).
  logic    v5;
  div_in_t s5;

  always_ff @(posedge clk) begin
    s5.e <= EW'(ep4[0]) + EW'(ep4[1]) + EW'(ep4[2]);
    for (int k = 0; k < DIMS; k++) begin
      s5.n[k] <= NW'(np4[k][0]) + NW'(np4[k][1]) + NW'(np4[k][2]);
    end
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  fps_divider #(
    .SAT_BITS (SAT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .din       (s5),
    .out_valid (done),
    .dout      (result)
  );

  // Every accepted transfer comes out after the fixed latency, and nothing else does.
  a_latency : assert property (@(posedge clk) disable iff (rst) acc |-> ##LAT done)
    else $error("accepted item gave no result at the expected edge");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("result without a matching accepted item");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0 && !result.clipped))
    else $error("degenerate result with non-zero position or clip flag");

endmodule
